// ===== src/sms_pkg.sv =====
// Shared types, field widths, codes and bit positions of the safe-motion servo model.
package sms_pkg;

  localparam int POS_W  = 32;
  localparam int DT_W   = 16;
  localparam int PROD_W = POS_W + DT_W;
  localparam int CW_W   = 16;
  localparam int ST_W   = 16;
  localparam int ANA_W  = 16;
  localparam int CMD_W  = 10;
  localparam int ACK_W  = 3;
  localparam int MON_W  = 2;
  localparam int FIX_W  = 5;
  localparam int SLS_N  = 4;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [1:0] {
    FUNC_FRAME  = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_INJECT = 2'd2,
    FUNC_CLEAR  = 2'd3
  } sms_func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_ENABLES     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RESTART_AFTER_ERROR = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_FLAGS         = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_ANALOG_READING      = CFG_IDX_W'(3);

  // Control word 0: zero-active requests and one-active acknowledges; control word 1: output 1
  localparam int CW0_STO       = 0;
  localparam int CW0_SS1       = 1;
  localparam int CW0_SS2       = 2;
  localparam int CW0_SOS       = 3;
  localparam int CW0_ERR_ACK   = 7;
  localparam int CW0_SLS_LO    = 8;
  localparam int CW0_RST_ACK   = 12;
  localparam int CW0_BRAKE     = 13;
  localparam int CW0_POS_RESET = 14;
  localparam int CW1_OUT1      = 12;

  // Latched command flags
  localparam int CF_STO    = 0;
  localparam int CF_SS1    = 1;
  localparam int CF_SS2    = 2;
  localparam int CF_SOS    = 3;
  localparam int CF_SLS_LO = 4;
  localparam int CF_BRAKE  = 8;
  localparam int CF_OUT1   = 9;
  localparam logic [CMD_W-1:0] CMD_RESET = 10'h10F;

  // Acknowledge history bits
  localparam int ACK_ERR = 0;
  localparam int ACK_RST = 1;
  localparam int ACK_POS = 2;

  // Fixed flag register bits
  localparam int FX_TEMP_OK   = 0;
  localparam int FX_INPUT1    = 1;
  localparam int FX_INPUT2    = 2;
  localparam int FX_ANA_DIAG  = 3;
  localparam int FX_ANA_VALID = 4;

  // Status word 0
  localparam int ST0_STO    = 0;
  localparam int ST0_SOS    = 3;
  localparam int ST0_ERROR  = 7;
  localparam int ST0_SS1    = 8;
  localparam int ST0_SS2    = 9;
  localparam int ST0_SLS_LO = 12;

  // Status word 1
  localparam int ST1_RESTART   = 0;
  localparam int ST1_BRAKE     = 1;
  localparam int ST1_TEMP_OK   = 2;
  localparam int ST1_POS_VALID = 3;
  localparam int ST1_VEL_VALID = 4;
  localparam int ST1_INPUT1    = 8;
  localparam int ST1_INPUT2    = 9;
  localparam int ST1_OUTPUT1   = 12;
  localparam int ST1_ANA_DIAG  = 14;
  localparam int ST1_ANA_VALID = 15;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             error;
    logic             restart;
  } sms_flags_t;

endpackage

// ===== src/sms_if.sv =====
// Valid/ready channel interfaces: command input, status result and register writes.
interface sms_in_if import sms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  sms_func_t                func;
  logic [CW_W-1:0]          control_word_0;
  logic [CW_W-1:0]          control_word_1;
  logic signed [POS_W-1:0]  requested_velocity;
  logic [DT_W-1:0]          time_step;
  logic                     restart_flag;

  modport source (output valid, func, control_word_0, control_word_1,
                  requested_velocity, time_step, restart_flag, input ready);
  modport sink   (input valid, func, control_word_0, control_word_1,
                  requested_velocity, time_step, restart_flag, output ready);
endinterface

interface sms_out_if import sms_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [ST_W-1:0]          status_word_0;
  logic [ST_W-1:0]          status_word_1;
  logic signed [POS_W-1:0]  axis_position;
  logic signed [POS_W-1:0]  axis_velocity;
  logic signed [ANA_W-1:0]  analog_value;

  modport source (output valid, status_word_0, status_word_1, axis_position,
                  axis_velocity, analog_value, input ready);
  modport sink   (input valid, status_word_0, status_word_1, axis_position,
                  axis_velocity, analog_value, output ready);
endinterface

interface sms_cfg_if import sms_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/safe_motion_servo_model.sv =====
// Top level of the safe-motion servo model: command, tick and error handling with position.
//
// Channels: in_ch takes one item per beat (func selects command frame, motion
// tick, inject error or clear error); out_ch returns exactly one result beat
// per item, in order, holding both status words, the rounded position, the
// velocity and the analog value. cfg_ch writes one register per beat and is
// always ready; write it only while no item is in flight.
// Pipeline: input register -> flag update and velocity x time-step multiply
// -> accumulator add -> rounding -> result register. One item is accepted
// every cycle while in_ch.ready is high, so the throughput is one item per
// cycle unless the receiver stalls. The 32x17 multiply and the accumulator
// add each have a stage of their own. Each stage moves on when the stage
// after it is empty or moving, so bubbles close up and a new beat is taken
// while a finished result still waits.
// Reset (rst_n low, synchronous): empties the pipeline, puts the registers at
// their defaults, STO/SS1/SS2/SOS and brake requested, error and restart
// demand clear, velocity and position zero.
// Receiver stall: the result register holds its beat; the stages behind it
// fill, and in_ch.ready drops only once every stage is full.
module safe_motion_servo_model import sms_pkg::*; #(
  parameter int POSITION_FRACTION_BITS = 16
) (
  input logic      clk,
  input logic      rst_n,
  sms_in_if.sink   in_ch,
  sms_out_if.source out_ch,
  sms_cfg_if.sink  cfg_ch
);

  localparam int FRAC_W   = POSITION_FRACTION_BITS;
  localparam int ACC_W    = POS_W + FRAC_W;
  localparam int UP_SHIFT = (FRAC_W >= DT_W) ? FRAC_W - DT_W : 0;
  localparam int DN_SHIFT = (FRAC_W < DT_W) ? DT_W - FRAC_W : 0;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W - 1);

  // Configuration registers
  logic [MON_W-1:0]        mon_en_r;
  logic                    restart_keep_r;
  logic [FIX_W-1:0]        fixed_flags_r;
  logic signed [ANA_W-1:0] analog_r;

  // Input stage
  logic                    s1_v_r;
  sms_func_t               s1_func_r;
  logic [CW_W-1:0]         s1_cw0_r;
  logic [CW_W-1:0]         s1_cw1_r;
  logic signed [POS_W-1:0] s1_vel_r;
  logic [DT_W-1:0]         s1_dt_r;
  logic                    s1_rflag_r;

  // Safety state
  logic [CMD_W-1:0]        cmd_r, cmd_nxt;
  logic [ACK_W-1:0]        ack_r, ack_nxt;
  logic                    err_r, err_nxt;
  logic                    rdem_r, rdem_nxt;
  logic signed [POS_W-1:0] vel_r, vel_nxt;
  logic [ACK_W-1:0]        acks, rise;
  logic                    tick_nxt, zero_nxt;
  logic                    motion_ok;
  sms_flags_t              flags_nxt;
  logic [ST_W-1:0]         st0_nxt, st1_nxt;
  logic signed [PROD_W:0]  prod_full;

  // Multiply stage
  logic                     s2_v_r;
  logic [ST_W-1:0]          s2_st0_r, s2_st1_r;
  logic signed [POS_W-1:0]  s2_vel_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic                     s2_tick_r, s2_zero_r;

  // Accumulate stage
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic signed [PROD_W-1:0] prod_shr;
  logic signed [ACC_W-1:0]  prod_ext, step;
  logic                     s3_v_r;
  logic [ST_W-1:0]          s3_st0_r, s3_st1_r;
  logic signed [POS_W-1:0]  s3_vel_r;
  logic [ACC_W-1:0]         s3_acc_r;

  // Result register
  logic [ACC_W-1:0]         round_sum;
  logic                     out_v_r;
  logic [ST_W-1:0]          out_st0_r, out_st1_r;
  logic signed [POS_W-1:0]  out_pos_r, out_vel_r;

  logic out_free, s3_free, s2_free, s1_free;

  // Stage k loads whenever it is empty or its contents move on
  assign out_free    = ~out_v_r | out_ch.ready;
  assign s3_free     = ~s3_v_r | out_free;
  assign s2_free     = ~s2_v_r | s3_free;
  assign s1_free     = ~s1_v_r | s2_free;
  assign in_ch.ready = s1_free;
  assign cfg_ch.ready = 1'b1;

  // Register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mon_en_r       <= 2'b11;
      restart_keep_r <= 1'b1;
      fixed_flags_r  <= FIX_W'(1);
      analog_r       <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MONITOR_ENABLES:     mon_en_r       <= cfg_ch.data[MON_W-1:0];
        CFG_RESTART_AFTER_ERROR: restart_keep_r <= cfg_ch.data[0];
        CFG_FIXED_FLAGS:         fixed_flags_r  <= cfg_ch.data[FIX_W-1:0];
        CFG_ANALOG_READING:      analog_r       <= cfg_ch.data[ANA_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && in_ch.valid) begin
      s1_func_r  <= in_ch.func;
      s1_cw0_r   <= in_ch.control_word_0;
      s1_cw1_r   <= in_ch.control_word_1;
      s1_vel_r   <= in_ch.requested_velocity;
      s1_dt_r    <= in_ch.time_step;
      s1_rflag_r <= in_ch.restart_flag;
    end
  end

  // Permit comes from the state before this item
  assign motion_ok = ~(err_r | rdem_r | cmd_r[CF_STO] | cmd_r[CF_SS1] |
                       (mon_en_r[0] & (cmd_r[CF_SS2] | cmd_r[CF_SOS])));

  // Apply the item to the safety state
  always_comb begin
    cmd_nxt  = cmd_r;
    ack_nxt  = ack_r;
    err_nxt  = err_r;
    rdem_nxt = rdem_r;
    vel_nxt  = vel_r;
    tick_nxt = 1'b0;
    zero_nxt = 1'b0;
    acks     = {s1_cw0_r[CW0_POS_RESET], s1_cw0_r[CW0_RST_ACK], s1_cw0_r[CW0_ERR_ACK]};
    rise     = acks & ~ack_r;
    case (s1_func_r)
      FUNC_FRAME: begin
        cmd_nxt[CF_STO]              = ~s1_cw0_r[CW0_STO];
        cmd_nxt[CF_SS1]              = ~s1_cw0_r[CW0_SS1];
        cmd_nxt[CF_SS2]              = ~s1_cw0_r[CW0_SS2];
        cmd_nxt[CF_SOS]              = ~s1_cw0_r[CW0_SOS];
        cmd_nxt[CF_SLS_LO +: SLS_N]  = ~s1_cw0_r[CW0_SLS_LO +: SLS_N];
        cmd_nxt[CF_BRAKE]            = ~s1_cw0_r[CW0_BRAKE];
        cmd_nxt[CF_OUT1]             = s1_cw1_r[CW1_OUT1];
        ack_nxt = acks;
        // Error acknowledge first, then restart acknowledge, then position reset
        if (rise[ACK_ERR]) begin
          err_nxt  = 1'b0;
          rdem_nxt = rdem_r & restart_keep_r;
        end
        if (rise[ACK_RST]) begin
          rdem_nxt = 1'b0;
        end
        zero_nxt = rise[ACK_POS];
      end
      FUNC_TICK: begin
        vel_nxt  = motion_ok ? s1_vel_r : '0;
        tick_nxt = 1'b1;
      end
      FUNC_INJECT: begin
        err_nxt  = 1'b1;
        rdem_nxt = s1_rflag_r;
      end
      default: begin
        err_nxt  = 1'b0;
        rdem_nxt = 1'b0;
      end
    endcase
    prod_full = vel_nxt * $signed({1'b0, s1_dt_r});
  end

  // Status words reflect the state after this item
  assign flags_nxt = {cmd_nxt, err_nxt, rdem_nxt};

  sms_status u_status (
    .flags         (flags_nxt),
    .mon_en        (mon_en_r),
    .fixed_flags   (fixed_flags_r),
    .status_word_0 (st0_nxt),
    .status_word_1 (st1_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r  <= CMD_RESET;
      ack_r  <= '0;
      err_r  <= 1'b0;
      rdem_r <= 1'b0;
      vel_r  <= '0;
      s2_v_r <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_v_r <= s1_v_r;
      end
      if (s2_free && s1_v_r) begin
        cmd_r  <= cmd_nxt;
        ack_r  <= ack_nxt;
        err_r  <= err_nxt;
        rdem_r <= rdem_nxt;
        vel_r  <= vel_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_v_r) begin
      s2_st0_r  <= st0_nxt;
      s2_st1_r  <= st1_nxt;
      s2_vel_r  <= vel_nxt;
      s2_prod_r <= prod_full[PROD_W-1:0];
      s2_tick_r <= tick_nxt;
      s2_zero_r <= zero_nxt;
    end
  end

  // Bring the Q32.16 product to the accumulator's fraction; floor when narrowing
  always_comb begin
    prod_shr = s2_prod_r >>> DN_SHIFT;
    prod_ext = ACC_W'(prod_shr);
    step     = prod_ext <<< UP_SHIFT;
    if (s2_zero_r) begin
      acc_nxt = '0;
    end else if (s2_tick_r) begin
      acc_nxt = acc_r + unsigned'(step);
    end else begin
      acc_nxt = acc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      s3_v_r <= 1'b0;
    end else begin
      if (s3_free) begin
        s3_v_r <= s2_v_r;
      end
      if (s3_free && s2_v_r) begin
        acc_r <= acc_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s3_free && s2_v_r) begin
      s3_st0_r <= s2_st0_r;
      s3_st1_r <= s2_st1_r;
      s3_vel_r <= s2_vel_r;
      s3_acc_r <= acc_nxt;
    end
  end

  // Half away from zero: add half, less one when negative, then keep the integer part
  assign round_sum = s3_acc_r + HALF - ACC_W'(s3_acc_r[ACC_W-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s3_v_r) begin
      out_st0_r <= s3_st0_r;
      out_st1_r <= s3_st1_r;
      out_pos_r <= round_sum[ACC_W-1 -: POS_W];
      out_vel_r <= s3_vel_r;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.status_word_0 = out_st0_r;
  assign out_ch.status_word_1 = out_st1_r;
  assign out_ch.axis_position = out_pos_r;
  assign out_ch.axis_velocity = out_vel_r;
  // The user must change registers only while idle (not enforced here); then the live value matches every beat
  assign out_ch.analog_value  = analog_r;

endmodule

// ===== src/sms_status.sv =====
// Status word packing from the safety flags.
module sms_status import sms_pkg::*; (
  input  sms_flags_t       flags,
  input  logic [MON_W-1:0] mon_en,
  input  logic [FIX_W-1:0] fixed_flags,
  output logic [ST_W-1:0]  status_word_0,
  output logic [ST_W-1:0]  status_word_1
);

  logic sto_on, ss1_on, ss2_on, sos_on, brake_on;

  always_comb begin
    sto_on   = flags.error | flags.cmd[CF_STO];
    ss1_on   = flags.error | flags.cmd[CF_SS1];
    ss2_on   = mon_en[0] & flags.cmd[CF_SS2];
    sos_on   = mon_en[0] & flags.cmd[CF_SOS];
    brake_on = flags.error | flags.cmd[CF_BRAKE] | sto_on | ss1_on;

    status_word_0 = '0;
    status_word_0[ST0_STO]   = sto_on;
    status_word_0[ST0_SOS]   = sos_on;
    status_word_0[ST0_ERROR] = flags.error;
    status_word_0[ST0_SS1]   = ss1_on;
    status_word_0[ST0_SS2]   = ss2_on;
    status_word_0[ST0_SLS_LO +: SLS_N] = mon_en[1] ? flags.cmd[CF_SLS_LO +: SLS_N] : '0;

    status_word_1 = '0;
    status_word_1[ST1_RESTART]   = flags.restart;
    status_word_1[ST1_BRAKE]     = brake_on;
    status_word_1[ST1_TEMP_OK]   = fixed_flags[FX_TEMP_OK];
    status_word_1[ST1_POS_VALID] = mon_en[0];
    status_word_1[ST1_VEL_VALID] = mon_en[1];
    status_word_1[ST1_INPUT1]    = fixed_flags[FX_INPUT1];
    status_word_1[ST1_INPUT2]    = fixed_flags[FX_INPUT2];
    status_word_1[ST1_OUTPUT1]   = flags.cmd[CF_OUT1];
    status_word_1[ST1_ANA_DIAG]  = fixed_flags[FX_ANA_DIAG];
    status_word_1[ST1_ANA_VALID] = fixed_flags[FX_ANA_VALID];
  end

endmodule

// ===== src/sms_checker.sv =====
// Port-level checks on the result channel of the servo model, bound to the top level.
module sms_checker import sms_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [ST_W-1:0]         status_word_0,
  input logic [ST_W-1:0]         status_word_1,
  input logic signed [POS_W-1:0] axis_position
);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  a_error_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status_word_0[ST0_ERROR] |->
      status_word_0[ST0_STO] && status_word_0[ST0_SS1] && status_word_1[ST1_BRAKE])
    else $error("error without STO, SS1 and brake");

  a_pos_monitor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_word_0[ST0_SS2] || status_word_0[ST0_SOS]) |->
      status_word_1[ST1_POS_VALID])
    else $error("SS2 or SOS reported with position monitoring off");

  a_vel_monitor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status_word_0[ST0_SLS_LO +: SLS_N] != '0) |->
      status_word_1[ST1_VEL_VALID])
    else $error("SLS reported with velocity monitoring off");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(status_word_0) && $stable(axis_position))
    else $error("stalled result beat changed");

endmodule

bind safe_motion_servo_model sms_checker u_sms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status_word_0 (out_ch.status_word_0),
  .status_word_1 (out_ch.status_word_1),
  .axis_position (out_ch.axis_position)
);
